// File: rtl/mcfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfe_pkg: shared types and constants of the command frame encoder
// Mode codes, register indexes, frame type codes and the front/back word.
// ----------------------------------------------------------------------------
package mcfe_pkg;

    typedef enum logic [2:0] {
        MODE_IMPEDANCE = 3'd0,
        MODE_ENABLE    = 3'd1,
        MODE_DISABLE   = 3'd2,
        MODE_CLR_FAULT = 3'd3,
        MODE_SET_ZERO  = 3'd4,
        MODE_SAVE      = 3'd5,
        MODE_CHANGE_ID = 3'd6,
        MODE_READ_PAR  = 3'd7
    } t_mode;

    localparam logic [2:0] REG_DEV_ADDR = 3'd0;
    localparam logic [2:0] REG_POS_OFS  = 3'd1;
    localparam logic [2:0] REG_POS_LIM  = 3'd2;
    localparam logic [2:0] REG_VEL_LIM  = 3'd3;
    localparam logic [2:0] REG_TRQ_LIM  = 3'd4;
    localparam logic [2:0] REG_KP_LIM   = 3'd5;
    localparam logic [2:0] REG_KD_LIM   = 3'd6;

    localparam logic [4:0] TYPE_MOTION  = 5'h01;
    localparam logic [4:0] TYPE_ENABLE  = 5'h03;
    localparam logic [4:0] TYPE_STOP    = 5'h04;
    localparam logic [4:0] TYPE_ZERO    = 5'h06;
    localparam logic [4:0] TYPE_SET_ID  = 5'h07;
    localparam logic [4:0] TYPE_READ    = 5'h11;
    localparam logic [4:0] TYPE_SAVE    = 5'h16;

    localparam int NCH = 5;  // channels: position, velocity, kp, kd, torque

    // Word handed from the front part to the back part.
    // d: clamped offset from range minimum (33 bits), s: span (32 bits).
    typedef struct packed {
        logic             quant;    // impedance word: quantize channels
        logic [28:0]      frame_id; // fixed id (area filled later if quant)
        logic [63:0]      payload;
        logic [NCH-1:0][32:0] d;
        logic [NCH-1:0][31:0] s;
    } t_job;

endpackage

// File: rtl/mcfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfe_front: command classification and range clamp
// Registers one accepted command as a job word: fixed frame fields, and for
// impedance commands the clamped offset and span of each channel.
// ----------------------------------------------------------------------------
module mcfe_front import mcfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_target_position,
    input  logic signed [31:0] i_target_velocity,
    input  logic signed [31:0] i_stiffness,
    input  logic signed [31:0] i_damping,
    input  logic signed [31:0] i_feedforward_torque,
    input  logic [7:0]         i_current_id,
    input  logic [7:0]         i_new_id,
    input  logic [7:0]         i_param_index,
    input  logic [7:0]         i_dev_addr,
    input  logic signed [31:0] i_pos_ofs,
    input  logic [30:0]        i_pos_lim,
    input  logic [30:0]        i_vel_lim,
    input  logic [30:0]        i_trq_lim,
    input  logic [30:0]        i_kp_lim,
    input  logic [30:0]        i_kd_lim,
    output logic               o_valid,
    input  logic               i_ready,
    output t_job               o_job
);

    logic r_valid;
    t_job r_job, n_job;

    // Clamp x to [-neg, hi_w - neg], return offset from minimum.
    function automatic logic [32:0] clampd(input logic signed [33:0] x,
                                           input logic [30:0] neg,
                                           input logic [31:0] hi_w);
        logic signed [33:0] lo, hi, v;
        lo = -$signed({3'b000, neg});
        hi = lo + $signed({2'b00, hi_w});
        v  = x;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        clampd = 33'(v - lo);
    endfunction

    always_comb begin
        logic signed [33:0] p;
        p = 34'(i_target_position) - 34'(i_pos_ofs);
        n_job = '0;
        n_job.payload = '0;
        case (t_mode'(i_mode))
            MODE_IMPEDANCE: begin
                n_job.quant    = 1'b1;
                n_job.frame_id = {TYPE_MOTION, 16'h0, i_dev_addr};
                n_job.s[0] = {i_pos_lim, 1'b0};
                n_job.s[1] = {i_vel_lim, 1'b0};
                n_job.s[2] = {1'b0, i_kp_lim};
                n_job.s[3] = {1'b0, i_kd_lim};
                n_job.s[4] = {i_trq_lim, 1'b0};
                n_job.d[0] = clampd(p, i_pos_lim, {i_pos_lim, 1'b0});
                n_job.d[1] = clampd(34'(i_target_velocity), i_vel_lim,
                                    {i_vel_lim, 1'b0});
                n_job.d[2] = clampd(34'(i_stiffness), '0, {1'b0, i_kp_lim});
                n_job.d[3] = clampd(34'(i_damping), '0, {1'b0, i_kd_lim});
                n_job.d[4] = clampd(34'(i_feedforward_torque), i_trq_lim,
                                    {i_trq_lim, 1'b0});
            end
            MODE_ENABLE:    n_job.frame_id = {TYPE_ENABLE, 16'h0, i_dev_addr};
            MODE_DISABLE:   n_job.frame_id = {TYPE_STOP, 16'h0, i_dev_addr};
            MODE_CLR_FAULT: begin
                n_job.frame_id = {TYPE_STOP, 16'h0, i_dev_addr};
                n_job.payload  = {8'h01, 56'h0};
            end
            MODE_SET_ZERO: begin
                n_job.frame_id = {TYPE_ZERO, 16'h0, i_dev_addr};
                n_job.payload  = {8'h01, 56'h0};
            end
            MODE_SAVE: begin
                n_job.frame_id = {TYPE_SAVE, 16'h0, i_dev_addr};
                n_job.payload  = {8'h01, 56'h0};
            end
            MODE_CHANGE_ID: begin
                n_job.frame_id = {TYPE_SET_ID, 16'h0, i_current_id};
                n_job.payload  = {i_new_id, 56'h0};
            end
            default: begin
                n_job.frame_id = {TYPE_READ, 16'h0, i_dev_addr};
                n_job.payload  = {i_param_index, 56'h0};
            end
        endcase
    end

    wire w_take = i_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (w_take) begin
            r_job <= n_job;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;

endmodule

// File: rtl/mcfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfe_queue: short job queue
// Two-entry queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module mcfe_queue import mcfe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    wire w_push = i_valid && o_ready;
    wire w_pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

endmodule

// File: rtl/mcfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfe_back: channel quantizer and frame output register
// Quantizes the five channels of an impedance job one per pass with a
// shared multiplier and a bit-serial divider, then presents the frame.
// ----------------------------------------------------------------------------
module mcfe_back import mcfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [28:0] o_frame_id,
    output logic [63:0] o_payload
);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} t_state;

    localparam int NW = 50;  // numerator width: 2*d*65535 + span < 2^50

    t_state          r_state;
    t_job            r_job;
    logic [2:0]      r_ch;
    logic [NW-1:0]   r_rem;   // numerator shifted out / remainder
    logic [NW-1:0]   r_quo;
    logic [5:0]      r_bit;
    logic [NW-1:0]   r_num;
    logic [32:0]     r_den;
    logic [NCH-1:0][15:0] r_code;
    logic            r_ovalid;
    logic [28:0]     r_oid;
    logic [63:0]     r_opay;

    wire w_slot = !r_ovalid || i_ready;
    assign o_ready = (r_state == ST_IDLE) && w_slot;

    // Load the output register from a fixed job or from the last channel.
    wire w_take = (r_state == ST_IDLE) && i_valid && w_slot;
    wire w_last = (r_state == ST_DONE) && (r_ch == 3'(NCH - 1)) && w_slot;
    wire w_load = (w_take && !i_job.quant) || w_last;

    logic [NW:0] w_trial;
    logic [NW-1:0] w_rsh;
    always_comb begin
        w_rsh   = {r_rem[NW-2:0], r_num[NW-1]};
        w_trial = {1'b0, w_rsh} - {{(NW-32){1'b0}}, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_job <= i_job;
                        r_ch  <= 3'd0;
                        if (i_job.quant) begin
                            r_state <= ST_MUL;
                        end else begin
                            r_oid  <= i_job.frame_id;
                            r_opay <= i_job.payload;
                        end
                    end
                end
                ST_MUL: begin
                    // numerator 2*d*65535 + span, denominator 2*span
                    r_num <= NW'({r_job.d[r_ch], 1'b0}) * NW'(17'd65535)
                           + NW'(r_job.s[r_ch]);
                    r_den <= {r_job.s[r_ch], 1'b0};
                    r_rem <= '0;
                    r_quo <= '0;
                    r_bit <= 6'(NW);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_den == '0) begin
                        r_code[r_ch] <= 16'h0;
                        r_state <= ST_DONE;
                    end else if (r_bit == 6'd0) begin
                        r_code[r_ch] <= (r_quo > NW'(16'hFFFF)) ? 16'hFFFF
                                                                 : r_quo[15:0];
                        r_state <= ST_DONE;
                    end else begin
                        r_num <= {r_num[NW-2:0], 1'b0};
                        if (!w_trial[NW]) begin
                            r_rem <= w_trial[NW-1:0];
                            r_quo <= {r_quo[NW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_quo <= {r_quo[NW-2:0], 1'b0};
                        end
                        r_bit <= r_bit - 6'd1;
                    end
                end
                ST_DONE: begin
                    if (r_ch != 3'(NCH - 1)) begin
                        r_ch    <= r_ch + 3'd1;
                        r_state <= ST_MUL;
                    end else if (w_slot) begin
                        r_oid    <= {r_job.frame_id[28:24], r_code[4],
                                     r_job.frame_id[7:0]};
                        r_opay   <= {r_code[0], r_code[1], r_code[2], r_code[3]};
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_frame_id = r_oid;
    assign o_payload  = r_opay;

endmodule

// File: rtl/motor_command_frame_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_command_frame_encoder_core: motor command to CAN frame encoder
// Turns each command word into one 29-bit extended-ID frame with 8 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the command fields and raise i_push while o_full is
//   low; the word is taken at that edge. Result channel: while o_empty is
//   low, o_frame_id and o_payload hold the oldest frame; raise i_pop to take
//   it. Configuration: i_cfg_we with i_cfg_addr/i_cfg_data writes one
//   register at the edge; write only while no command is in flight.
//   Flow: fixed-payload modes pass the front register, the job queue and
//   the frame register, and can stream one word per cycle while i_pop
//   takes each frame. Impedance commands quantize five channels in sequence
//   through one multiplier and a one-bit-per-cycle divider, one job at a time.
//   A two-entry job queue sits between the classifier and the quantizer and
//   the output frame register is separate from the quantizer, so the input
//   keeps accepting while a frame waits on a stalled receiver; when all
//   stages fill, o_full rises and holds until the quantizer takes a job,
//   which needs a free frame register (i_pop) and an idle quantizer.
//   Reset (synchronous, i_rst_n low) empties every stage and loads the
//   register defaults.
// ----------------------------------------------------------------------------
module motor_command_frame_encoder_core import mcfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_target_position,
    input  logic signed [31:0] i_target_velocity,
    input  logic signed [31:0] i_stiffness,
    input  logic signed [31:0] i_damping,
    input  logic signed [31:0] i_feedforward_torque,
    input  logic [7:0]         i_current_id,
    input  logic [7:0]         i_new_id,
    input  logic [7:0]         i_param_index,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [28:0]        o_frame_id,
    output logic [63:0]        o_payload,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_data
);

    logic [7:0]         r_dev_addr;
    logic signed [31:0] r_pos_ofs;
    logic [30:0]        r_pos_lim, r_vel_lim, r_trq_lim, r_kp_lim, r_kd_lim;

    // Hold register values; load one on a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 8'd1;
            r_pos_ofs  <= '0;
            r_pos_lim  <= 31'd823550;
            r_vel_lim  <= 31'd1310720;
            r_trq_lim  <= 31'd3932160;
            r_kp_lim   <= 31'd327680000;
            r_kd_lim   <= 31'd6553600;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DEV_ADDR: r_dev_addr <= i_cfg_data[7:0];
                REG_POS_OFS:  r_pos_ofs  <= i_cfg_data;
                REG_POS_LIM:  r_pos_lim  <= i_cfg_data[30:0];
                REG_VEL_LIM:  r_vel_lim  <= i_cfg_data[30:0];
                REG_TRQ_LIM:  r_trq_lim  <= i_cfg_data[30:0];
                REG_KP_LIM:   r_kp_lim   <= i_cfg_data[30:0];
                REG_KD_LIM:   r_kd_lim   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    logic f_valid, f_ready, q_valid, q_ready, b_valid;
    t_job f_job, q_job;

    mcfe_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_push),
        .i_mode, .i_target_position, .i_target_velocity, .i_stiffness,
        .i_damping, .i_feedforward_torque, .i_current_id, .i_new_id,
        .i_param_index,
        .i_dev_addr(r_dev_addr), .i_pos_ofs(r_pos_ofs), .i_pos_lim(r_pos_lim),
        .i_vel_lim(r_vel_lim), .i_trq_lim(r_trq_lim), .i_kp_lim(r_kp_lim),
        .i_kd_lim(r_kd_lim),
        .o_valid(f_valid), .i_ready(f_ready), .o_job(f_job)
    );

    // Front takes a word when its stage is empty or draining into the queue.
    assign o_full = f_valid && !f_ready;

    mcfe_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job)
    );

    mcfe_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_job(q_job),
        .o_valid(b_valid), .i_ready(i_pop),
        .o_frame_id, .o_payload
    );

    assign o_empty = !b_valid;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for motor_command_frame_encoder_core
// Drives commands of every mode through several register settings (reset
// defaults, widest and narrowest limits, zero limits, random settings).
// Every frame popped from the block is checked against a frame computed
// from the command and the current register copy.
// ----------------------------------------------------------------------------
module tb;
    import mcfe_pkg::*;

    typedef struct {
        t_mode              mode;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] kp;
        logic signed [31:0] kd;
        logic signed [31:0] trq;
        logic [7:0]         cur_id;
        logic [7:0]         nid;
        logic [7:0]         pidx;
    } t_cmd;

    // Frame scoreboard: holds a register copy and the frames still owed.
    class frame_board;
        logic [7:0]  dev_addr;
        longint      pos_ofs;
        longint      pos_lim, vel_lim, trq_lim, kp_lim, kd_lim;
        logic [28:0] id_q[$];
        logic [63:0] pay_q[$];
        int          errors;
        int          checked;
        int          per_mode[8];

        function void load_defaults();
            dev_addr = 8'd1;
            pos_ofs  = 0;
            pos_lim  = 823550;
            vel_lim  = 1310720;
            trq_lim  = 3932160;
            kp_lim   = 327680000;
            kd_lim   = 6553600;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_DEV_ADDR: dev_addr = val[7:0];
                REG_POS_OFS:  pos_ofs  = longint'($signed(val));
                REG_POS_LIM:  pos_lim  = longint'(val[30:0]);
                REG_VEL_LIM:  vel_lim  = longint'(val[30:0]);
                REG_TRQ_LIM:  trq_lim  = longint'(val[30:0]);
                REG_KP_LIM:   kp_lim   = longint'(val[30:0]);
                REG_KD_LIM:   kd_lim   = longint'(val[30:0]);
                default: ;
            endcase
        endfunction

        // Clamp to [lo, lo+span], then round into 16 bits.
        function logic [15:0] quant16(longint x, longint lo, longint span);
            longint hi;
            longint d;
            longint q;
            if (span == 0) return 16'd0;
            hi = lo + span;
            if (x > hi) x = hi;
            if (x < lo) x = lo;
            d = x - lo;
            q = (2 * d * 65535 + span) / (2 * span);
            if (q > 65535) q = 65535;
            return q[15:0];
        endfunction

        function logic [28:0] pack_id(logic [4:0] ftype, logic [15:0] area,
                                      logic [7:0] target);
            return {ftype, area, target};
        endfunction

        // Note an accepted command: compute the frame it must produce.
        function void note_command(t_cmd c);
            logic [28:0] fid;
            logic [63:0] pay;
            logic [15:0] pc, vc, kc, dc, tc;
            pay = '0;
            per_mode[c.mode]++;
            case (c.mode)
                MODE_IMPEDANCE: begin
                    pc  = quant16(longint'(c.pos) - pos_ofs, -pos_lim, 2 * pos_lim);
                    vc  = quant16(longint'(c.vel), -vel_lim, 2 * vel_lim);
                    kc  = quant16(longint'(c.kp), 0, kp_lim);
                    dc  = quant16(longint'(c.kd), 0, kd_lim);
                    tc  = quant16(longint'(c.trq), -trq_lim, 2 * trq_lim);
                    fid = pack_id(TYPE_MOTION, tc, dev_addr);
                    pay = {pc, vc, kc, dc};
                end
                MODE_ENABLE:    fid = pack_id(TYPE_ENABLE, 16'd0, dev_addr);
                MODE_DISABLE:   fid = pack_id(TYPE_STOP, 16'd0, dev_addr);
                MODE_CLR_FAULT: begin
                    fid = pack_id(TYPE_STOP, 16'd0, dev_addr);
                    pay = {8'd1, 56'd0};
                end
                MODE_SET_ZERO: begin
                    fid = pack_id(TYPE_ZERO, 16'd0, dev_addr);
                    pay = {8'd1, 56'd0};
                end
                MODE_SAVE: begin
                    fid = pack_id(TYPE_SAVE, 16'd0, dev_addr);
                    pay = {8'd1, 56'd0};
                end
                MODE_CHANGE_ID: begin
                    fid = pack_id(TYPE_SET_ID, 16'd0, c.cur_id);
                    pay = {c.nid, 56'd0};
                end
                default: begin
                    fid = pack_id(TYPE_READ, 16'd0, dev_addr);
                    pay = {c.pidx, 56'd0};
                end
            endcase
            id_q.push_back(fid);
            pay_q.push_back(pay);
        endfunction

        // Check one popped frame against the oldest owed frame.
        function void check_frame(logic [28:0] fid, logic [63:0] pay);
            logic [28:0] exp_id;
            logic [63:0] exp_pay;
            if (id_q.size() == 0) begin
                $display("%0t: unexpected frame id=%h payload=%h", $time, fid, pay);
                errors++;
                return;
            end
            exp_id  = id_q.pop_front();
            exp_pay = pay_q.pop_front();
            checked++;
            if (fid !== exp_id) begin
                $display("%0t: frame_id expected %h actual %h", $time, exp_id, fid);
                errors++;
            end
            if (pay !== exp_pay) begin
                $display("%0t: payload expected %h actual %h", $time, exp_pay, pay);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_push;
    logic               o_full;
    logic [2:0]         i_mode;
    logic signed [31:0] i_target_position;
    logic signed [31:0] i_target_velocity;
    logic signed [31:0] i_stiffness;
    logic signed [31:0] i_damping;
    logic signed [31:0] i_feedforward_torque;
    logic [7:0]         i_current_id;
    logic [7:0]         i_new_id;
    logic [7:0]         i_param_index;
    logic               o_empty;
    logic               i_pop;
    logic [28:0]        o_frame_id;
    logic [63:0]        o_payload;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_addr;
    logic [31:0]        i_cfg_data;

    frame_board board;
    int         idle_cycles;
    int         stall_style;

    localparam int WATCHDOG_LIMIT = 20000;

    motor_command_frame_encoder_core dut (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Drive a known value on every input before the first edge.
    initial begin
        board = new();
        board.load_defaults();
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_mode = MODE_ENABLE;
        i_target_position = '0;
        i_target_velocity = '0;
        i_stiffness = '0;
        i_damping = '0;
        i_feedforward_torque = '0;
        i_current_id = '0;
        i_new_id = '0;
        i_param_index = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_DEV_ADDR;
        i_cfg_data = '0;
    end

    // Watchdog: count cycles in which no word moves on either side.
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired at %0t", $time);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Check every frame taken at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) board.check_frame(o_frame_id, o_payload);
    end

    // Receiver stall pattern: change style now and then; one style never
    // stalls, the others stall in short or long runs.
    initial begin
        int run;
        stall_style = 0;
        run = 0;
        forever begin
            @(negedge i_clk);
            if (run == 0) begin
                stall_style = $urandom_range(0, 3);
                run = $urandom_range(20, 300);
            end
            run--;
            case (stall_style)
                0: i_pop <= 1'b1;
                1: i_pop <= ($urandom_range(0, 3) != 0);
                2: i_pop <= ($urandom_range(0, 1) != 0);
                default: i_pop <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // Write one register while nothing is in flight.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_reg(idx, val);
    endtask

    // Hold off until every owed frame has been popped, then let the
    // pipeline settle.
    task automatic drain();
        while (board.id_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // Present one command and hold it until the block takes it.
    task automatic push_cmd(t_cmd c);
        @(negedge i_clk);
        i_push               <= 1'b1;
        i_mode               <= c.mode;
        i_target_position    <= c.pos;
        i_target_velocity    <= c.vel;
        i_stiffness          <= c.kp;
        i_damping            <= c.kd;
        i_feedforward_torque <= c.trq;
        i_current_id         <= c.cur_id;
        i_new_id             <= c.nid;
        i_param_index        <= c.pidx;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        board.note_command(c);
    endtask

    task automatic pause_sender(int n);
        @(negedge i_clk);
        i_push <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Pick a value near the given half-width: extremes, edges, inside.
    function automatic logic signed [31:0] pick_val(longint lim);
        longint v;
        case ($urandom_range(0, 7))
            0: v = longint'($signed($urandom));
            1: v = lim;
            2: v = -lim;
            3: v = lim + $urandom_range(0, 3);
            4: v = -lim - $urandom_range(0, 3);
            5: v = $urandom_range(0, 1) ? 64'sh7FFFFFFF : -64'sh80000000;
            default: begin
                v = longint'($urandom) % (lim + 1);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
        if (v < -64'sh80000000) v = -64'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        c.mode   = $urandom_range(0, 1) ? MODE_IMPEDANCE : t_mode'($urandom_range(0, 7));
        c.pos    = pick_val(board.pos_lim + board.pos_ofs);
        if ($urandom_range(0, 1)) c.pos = 32'(pick_val(board.pos_lim) + board.pos_ofs);
        c.vel    = pick_val(board.vel_lim);
        c.kp     = pick_val(board.kp_lim);
        c.kd     = pick_val(board.kd_lim);
        c.trq    = pick_val(board.trq_lim);
        c.cur_id = 8'($urandom);
        c.nid    = 8'($urandom);
        c.pidx   = 8'($urandom);
        return c;
    endfunction

    // Send n random commands in bursts with random gaps.
    task automatic random_burst(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0) begin
                push_cmd(random_cmd());
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
        end
        pause_sender(0);
    endtask

    function automatic t_cmd fixed_cmd(t_mode m, logic signed [31:0] v, logic [7:0] b);
        t_cmd c;
        c.mode = m;
        c.pos = v;
        c.vel = v;
        c.kp = v;
        c.kd = v;
        c.trq = v;
        c.cur_id = b;
        c.nid = ~b;
        c.pidx = b;
        return c;
    endfunction

    task automatic write_all(logic [31:0] addr, logic [31:0] ofs, logic [31:0] lim);
        write_reg(REG_DEV_ADDR, addr);
        write_reg(REG_POS_OFS, ofs);
        write_reg(REG_POS_LIM, lim);
        write_reg(REG_VEL_LIM, lim);
        write_reg(REG_TRQ_LIM, lim);
        write_reg(REG_KP_LIM, lim);
        write_reg(REG_KD_LIM, lim);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every mode, field extremes, zero and in-range values.
        for (int m = 0; m < 8; m++) push_cmd(fixed_cmd(t_mode'(m), 32'sh7FFFFFFF, 8'hFF));
        push_cmd(fixed_cmd(MODE_IMPEDANCE, -32'sh80000000, 8'h00));
        push_cmd(fixed_cmd(MODE_IMPEDANCE, 32'sd0, 8'h5A));
        push_cmd(fixed_cmd(MODE_IMPEDANCE, 32'sd65536, 8'hA5));
        push_cmd(fixed_cmd(MODE_IMPEDANCE, -32'sd823550, 8'h01));
        push_cmd(fixed_cmd(MODE_CHANGE_ID, 32'sd0, 8'h00));
        push_cmd(fixed_cmd(MODE_READ_PAR, 32'sd0, 8'h80));
        pause_sender(0);
        // Hold the sender until every frame is back.
        drain();
        random_burst(200);
        drain();

        // Widest limits, offset at its most negative: position minus
        // offset runs past 32 bits without wrapping.
        write_all(32'hFF, 32'h80000000, 32'h7FFFFFFF);
        push_cmd(fixed_cmd(MODE_IMPEDANCE, 32'sh7FFFFFFF, 8'h11));
        random_burst(220);
        drain();

        // Narrowest legal limits, offset at its most positive.
        write_all(32'h00, 32'h7FFFFFFF, 32'h1);
        push_cmd(fixed_cmd(MODE_IMPEDANCE, -32'sh80000000, 8'h22));
        random_burst(220);
        drain();

        // Zero limits: every channel collapses to a single point.
        write_all(32'h3C, 32'h0, 32'h0);
        random_burst(100);
        drain();

        // Random settings: every register gets a new random value in each phase.
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_DEV_ADDR, $urandom);
            write_reg(REG_POS_OFS, $urandom);
            write_reg(REG_POS_LIM, $urandom_range(1, 32'h7FFFFFFF) >> $urandom_range(0, 24));
            write_reg(REG_VEL_LIM, $urandom_range(1, 32'h7FFFFFFF) >> $urandom_range(0, 24));
            write_reg(REG_TRQ_LIM, $urandom_range(1, 32'h7FFFFFFF) >> $urandom_range(0, 24));
            write_reg(REG_KP_LIM, $urandom_range(1, 32'h7FFFFFFF) >> $urandom_range(0, 24));
            write_reg(REG_KD_LIM, $urandom_range(1, 32'h7FFFFFFF) >> $urandom_range(0, 24));
            random_burst(200);
            drain();
        end

        $display("checked %0d frames over 7 register settings", board.checked);
        $display("by mode: imp %0d en %0d dis %0d clr %0d zero %0d save %0d id %0d rd %0d",
                 board.per_mode[0], board.per_mode[1], board.per_mode[2],
                 board.per_mode[3], board.per_mode[4], board.per_mode[5],
                 board.per_mode[6], board.per_mode[7]);
        if (board.errors == 0 && board.id_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/mcfe_pkg.sv
rtl/mcfe_front.sv
rtl/mcfe_queue.sv
rtl/mcfe_back.sv
rtl/motor_command_frame_encoder_core.sv
sim/tb.sv
